// ===== sv/pitb_pkg.sv =====
// ----------------------------------------------------------------------------
// pitb_pkg
// Shared constants, types and pair helpers for the barycentric triangle test.
// ----------------------------------------------------------------------------
package pitb_pkg;

    localparam int unsigned IN_W       = 16;
    localparam int unsigned N_FIELDS   = 12;
    localparam int unsigned IN_DATA_W  = IN_W * N_FIELDS;
    localparam int unsigned TOL_W      = 16;
    localparam int unsigned OUT_W      = 24;
    localparam int unsigned OUT_DATA_W = 80;
    localparam int unsigned QB         = 47;
    localparam int unsigned N_AXIS     = 3;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_PTR_W    = 2;

    typedef enum logic [1:0] {
        PAIR_XY = 2'd0,
        PAIR_XZ = 2'd1,
        PAIR_YZ = 2'd2
    } t_pair;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [1:0] pair_i(input t_pair p);
        logic [1:0] r;
        case (p)
            PAIR_XY: r = 2'd0;
            PAIR_XZ: r = 2'd0;
            PAIR_YZ: r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_j(input t_pair p);
        logic [1:0] r;
        case (p)
            PAIR_XY: r = 2'd1;
            PAIR_XZ: r = 2'd2;
            PAIR_YZ: r = 2'd2;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/point_in_triangle_barycentric_core.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_barycentric_core
// Pipeline depth is set mainly by the 47-stage one-bit-per-stage divider.
// Throughput: one transaction per cycle while the master side keeps accepting results.
// Reset: synchronous active-low i_rst_n empties the pipeline and queue and
//   clears tolerance to 0.
// ----------------------------------------------------------------------------
module point_in_triangle_barycentric_core import pitb_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z q_x q_y q_z, 16 bits each
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // bary_0[23:0] bary_1[47:24] bary_2[71:48] inside_res[72] degenerate[73]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [TOL_W-1:0]      i_cfg_wdata
);

    localparam int MW = 2 * COORD_BITS + 3;
    localparam int EW = 3 * MW + 3;

    logic [TOL_W-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    logic          push, pop;
    logic [EW-1:0] push_data, head_data;
    t_q_stat       q_stat;

    pitb_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_entry  (push_data)
    );

    pitb_queue #(.EW(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_stat  (q_stat)
    );

    pitb_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_entry  (head_data),
        .o_pop    (pop),
        .i_tol    (r_tol),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

// ===== sv/pitb_front.sv =====
// ----------------------------------------------------------------------------
// pitb_front
// Accepts transactions, forms pair determinants, picks the dominant pair and
// its numerators, and pushes magnitudes and signs into the queue.
// ----------------------------------------------------------------------------
module pitb_front import pitb_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tvalid,
    output logic                               o_tready,
    input  logic [IN_DATA_W-1:0]               i_tdata,
    input  logic                               i_q_full,
    output logic                               o_push,
    output logic [3*(2*COORD_BITS+3)+2:0]      o_entry
);

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 2;
    localparam int MW = 2 * CW + 3;

    function automatic logic signed [CW-1:0] field_coord(input logic [IN_W-1:0] f);
        logic [CW+IN_W-1:0] t;
        t = {{CW{1'b0}}, f};
        return $signed(t[CW-1:0]);
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
        return v[MW-1] ? (~v + 1'b1) : v;
    endfunction

    logic       fe;
    logic [5:0] r_v;

    assign fe       = !(r_v[5] && i_q_full);
    assign o_tready = fe;
    assign o_push   = r_v[5] && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (fe) begin
            r_v <= {r_v[4:0], i_tvalid};
        end
    end

    // stage 1: differences against the third vertex
    logic signed [CW-1:0] c_a0 [N_AXIS];
    logic signed [CW-1:0] c_a1 [N_AXIS];
    logic signed [CW-1:0] c_a2 [N_AXIS];
    logic signed [CW-1:0] c_q  [N_AXIS];
    logic signed [DW-1:0] r1_e0 [N_AXIS];
    logic signed [DW-1:0] r1_e1 [N_AXIS];
    logic signed [DW-1:0] r1_p  [N_AXIS];

    always_comb begin
        for (int c = 0; c < N_AXIS; c++) begin
            c_a0[c] = field_coord(i_tdata[IN_W*c +: IN_W]);
            c_a1[c] = field_coord(i_tdata[IN_W*(3+c) +: IN_W]);
            c_a2[c] = field_coord(i_tdata[IN_W*(6+c) +: IN_W]);
            c_q[c]  = field_coord(i_tdata[IN_W*(9+c) +: IN_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            for (int c = 0; c < N_AXIS; c++) begin
                r1_e0[c] <= {c_a0[c][CW-1], c_a0[c]} - {c_a2[c][CW-1], c_a2[c]};
                r1_e1[c] <= {c_a1[c][CW-1], c_a1[c]} - {c_a2[c][CW-1], c_a2[c]};
                r1_p[c]  <= {c_q[c][CW-1], c_q[c]} - {c_a2[c][CW-1], c_a2[c]};
            end
        end
    end

    // stage 2: determinant products
    logic signed [PW-1:0] r2_ma [N_AXIS];
    logic signed [PW-1:0] r2_mb [N_AXIS];
    logic signed [DW-1:0] r2_e0 [N_AXIS];
    logic signed [DW-1:0] r2_e1 [N_AXIS];
    logic signed [DW-1:0] r2_p  [N_AXIS];

    always_ff @(posedge i_clk) begin
        if (fe) begin
            for (int k = 0; k < N_AXIS; k++) begin
                r2_ma[k] <= r1_e1[pair_j(t_pair'(2'(k)))] * r1_e0[pair_i(t_pair'(2'(k)))];
                r2_mb[k] <= r1_e1[pair_i(t_pair'(2'(k)))] * r1_e0[pair_j(t_pair'(2'(k)))];
                r2_e0[k] <= r1_e0[k];
                r2_e1[k] <= r1_e1[k];
                r2_p[k]  <= r1_p[k];
            end
        end
    end

    // stage 3: determinants
    logic signed [MW-1:0] r3_d  [N_AXIS];
    logic signed [DW-1:0] r3_e0 [N_AXIS];
    logic signed [DW-1:0] r3_e1 [N_AXIS];
    logic signed [DW-1:0] r3_p  [N_AXIS];

    always_ff @(posedge i_clk) begin
        if (fe) begin
            for (int k = 0; k < N_AXIS; k++) begin
                r3_d[k]  <= {r2_ma[k][PW-1], r2_ma[k]} - {r2_mb[k][PW-1], r2_mb[k]};
                r3_e0[k] <= r2_e0[k];
                r3_e1[k] <= r2_e1[k];
                r3_p[k]  <= r2_p[k];
            end
        end
    end

    // stage 4: pick the dominant pair, ties keep the earlier one
    logic [MW-1:0]        c_m [N_AXIS];
    logic [MW-1:0]        c_bm;
    t_pair                c_best;
    logic [1:0]           c_i;
    logic [1:0]           c_j;
    logic signed [MW-1:0] r4_d;
    logic signed [DW-1:0] r4_e0i, r4_e0j, r4_e1i, r4_e1j, r4_pi, r4_pj;
    logic                 r4_deg;

    always_comb begin
        for (int k = 0; k < N_AXIS; k++) begin
            c_m[k] = mag(r3_d[k]);
        end
        c_best = PAIR_XY;
        c_bm   = c_m[0];
        if (c_m[1] > c_bm) begin
            c_best = PAIR_XZ;
            c_bm   = c_m[1];
        end
        if (c_m[2] > c_bm) begin
            c_best = PAIR_YZ;
            c_bm   = c_m[2];
        end
        c_i = pair_i(c_best);
        c_j = pair_j(c_best);
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r4_d   <= r3_d[c_best];
            r4_e0i <= r3_e0[c_i];
            r4_e0j <= r3_e0[c_j];
            r4_e1i <= r3_e1[c_i];
            r4_e1j <= r3_e1[c_j];
            r4_pi  <= r3_p[c_i];
            r4_pj  <= r3_p[c_j];
            r4_deg <= (c_bm == '0);
        end
    end

    // stage 5: numerator products
    logic signed [PW-1:0] r5_a, r5_b, r5_c, r5_e;
    logic signed [MW-1:0] r5_d;
    logic                 r5_deg;

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r5_a   <= r4_e1j * r4_pi;
            r5_b   <= r4_e1i * r4_pj;
            r5_c   <= r4_e0j * r4_pi;
            r5_e   <= r4_e0i * r4_pj;
            r5_d   <= r4_d;
            r5_deg <= r4_deg;
        end
    end

    // stage 6: numerators
    logic signed [MW-1:0] r6_n0, r6_n1, r6_d;
    logic                 r6_deg;

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r6_n0  <= {r5_a[PW-1], r5_a} - {r5_b[PW-1], r5_b};
            r6_n1  <= {r5_e[PW-1], r5_e} - {r5_c[PW-1], r5_c};
            r6_d   <= r5_d;
            r6_deg <= r5_deg;
        end
    end

    assign o_entry = {r6_deg,
                      r6_n1[MW-1] ^ r6_d[MW-1],
                      r6_n0[MW-1] ^ r6_d[MW-1],
                      mag(r6_n1), mag(r6_n0), mag(r6_d)};

endmodule

// ===== sv/pitb_queue.sv =====
// ----------------------------------------------------------------------------
// pitb_queue
// Small FIFO that decouples the classify front from the divide back.
// ----------------------------------------------------------------------------
module pitb_queue import pitb_pkg::*; #(
    parameter int EW = 57
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [EW-1:0] i_data,
    input  logic          i_pop,
    output logic [EW-1:0] o_data,
    output t_q_stat       o_stat
);

    logic [EW-1:0]      r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== sv/pitb_div.sv =====
// ----------------------------------------------------------------------------
// pitb_div
// Pipelined restoring divider, one quotient bit per stage, producing
// num * 2^FRAC_BITS / den truncated and held at 2^QB - 1.
// ----------------------------------------------------------------------------
module pitb_div import pitb_pkg::*; #(
    parameter int MW        = 35,
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [MW-1:0] i_num,
    input  logic [MW-1:0] i_den,
    output logic [QB-1:0] o_quo
);

    localparam int XW = QB + MW;

    logic [XW-1:0] c_nx;
    logic [MW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_low [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [MW-1:0] r_den [QB+1];
    logic          r_ovf [QB+1];

    assign c_nx = XW'(i_num) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= c_nx[XW-1:QB];
            r_low[0] <= c_nx[QB-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= (c_nx[XW-1:QB] >= i_den);
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [MW:0] c_t;
        logic [MW:0] c_diff;
        logic        c_ge;

        assign c_t    = {r_rem[s], r_low[s][QB-1]};
        assign c_diff = c_t - {1'b0, r_den[s]};
        assign c_ge   = (c_t >= {1'b0, r_den[s]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= c_ge ? c_diff[MW-1:0] : c_t[MW-1:0];
                r_low[s+1] <= {r_low[s][QB-2:0], 1'b0};
                r_q[s+1]   <= {r_q[s][QB-2:0], c_ge};
                r_den[s+1] <= r_den[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    assign o_quo = r_ovf[QB] ? '1 : r_q[QB];

endmodule

// ===== sv/pitb_back.sv =====
// ----------------------------------------------------------------------------
// pitb_back
// Pops queued transactions, divides both numerators, forms the third weight,
// clamps, runs the tolerance test and holds the result for the master side.
// ----------------------------------------------------------------------------
module pitb_back import pitb_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_q_stat                       i_q_stat,
    input  logic [3*(2*COORD_BITS+3)+2:0] i_entry,
    output logic                          o_pop,
    input  logic [TOL_W-1:0]              i_tol,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [OUT_DATA_W-1:0]         o_tdata
);

    localparam int MW = 2 * COORD_BITS + 3;
    localparam int LW = QB + 3;
    localparam logic signed [LW-1:0] ONE  = LW'(1) << FRAC_BITS;
    localparam logic signed [LW-1:0] OMAX = LW'((1 << (OUT_W-1)) - 1);
    localparam logic signed [LW-1:0] OMIN = -OMAX - LW'(1);

    function automatic logic [OUT_W-1:0] sat(input logic signed [LW-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > OMAX) begin
            r = OMAX[OUT_W-1:0];
        end else if (v < OMIN) begin
            r = OMIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    logic en;
    logic r_out_v;

    assign en    = !r_out_v || i_tready;
    assign o_pop = en && !i_q_stat.empty;

    logic [QB-1:0] c_q0, c_q1;

    pitb_div #(.MW(MW), .FRAC_BITS(FRAC_BITS)) u_div0 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (i_entry[2*MW-1:MW]),
        .i_den (i_entry[MW-1:0]),
        .o_quo (c_q0)
    );

    pitb_div #(.MW(MW), .FRAC_BITS(FRAC_BITS)) u_div1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (i_entry[3*MW-1:2*MW]),
        .i_den (i_entry[MW-1:0]),
        .o_quo (c_q1)
    );

    logic [QB:0] r_sv, r_s0, r_s1, r_sdeg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (en) begin
            r_sv <= {r_sv[QB-1:0], !i_q_stat.empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0   <= {r_s0[QB-1:0], i_entry[3*MW]};
            r_s1   <= {r_s1[QB-1:0], i_entry[3*MW+1]};
            r_sdeg <= {r_sdeg[QB-1:0], i_entry[3*MW+2]};
        end
    end

    // signed weights
    logic signed [LW-1:0] c_m0, c_m1, c_l0, c_l1;
    logic signed [LW-1:0] r_l0, r_l1, r_l2;
    logic                 r_ldeg, r_lv;

    assign c_m0 = {{(LW-QB){1'b0}}, c_q0};
    assign c_m1 = {{(LW-QB){1'b0}}, c_q1};
    assign c_l0 = r_s0[QB] ? -c_m0 : c_m0;
    assign c_l1 = r_s1[QB] ? -c_m1 : c_m1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l0   <= c_l0;
            r_l1   <= c_l1;
            r_l2   <= ONE - c_l0 - c_l1;
            r_ldeg <= r_sdeg[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_lv    <= r_sv[QB];
            r_out_v <= r_lv;
        end
    end

    // tolerance band and output register
    logic signed [LW-1:0]  c_tol, c_lo, c_hi;
    logic                  c_in;
    logic [OUT_DATA_W-1:0] r_data;

    assign c_tol = $signed({{(LW-TOL_W){1'b0}}, i_tol});
    assign c_lo  = -c_tol;
    assign c_hi  = ONE + c_tol;
    assign c_in  = (r_l0 >= c_lo) && (r_l0 <= c_hi) &&
                   (r_l1 >= c_lo) && (r_l1 <= c_hi) &&
                   (r_l2 >= c_lo) && (r_l2 <= c_hi);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_ldeg) begin
                r_data <= {{(OUT_DATA_W-3*OUT_W-2){1'b0}}, 1'b1, 1'b0, {(3*OUT_W){1'b0}}};
            end else begin
                r_data <= {{(OUT_DATA_W-3*OUT_W-2){1'b0}}, 1'b0, c_in,
                           sat(r_l2), sat(r_l1), sat(r_l0)};
            end
        end
    end

    assign o_tvalid = r_out_v;
    assign o_tdata  = r_data;

endmodule

// ===== verif/point_in_triangle_barycentric_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_triangle_barycentric_core_tb
// Drives triangle/point queries into the core and checks the barycentric
// weights, inside flag and degenerate flag against a built-in predictor,
// under several tolerance settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module point_in_triangle_barycentric_core_tb;
    import pitb_pkg::*;

    localparam int FRAC = 16;
    localparam longint QMAG = (64'sd1 <<< QB) - 1;
    localparam longint WMAX = 8388607;
    localparam longint WMIN = -8388608;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic       degenerate;
        logic       inside_res;
        logic [23:0] bary_2;
        logic [23:0] bary_1;
        logic [23:0] bary_0;
    } t_weights;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we;
    logic [TOL_W-1:0]      i_cfg_wdata;

    t_weights expected_weights[$];
    logic [15:0] tol_now;
    int n_errors;
    int idle_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    point_in_triangle_barycentric_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint fixed_quot(input longint num, input longint den);
        longint un, ud, q;
        un = mag(num);
        ud = mag(den);
        if (un / ud >= (64'sd1 <<< (QB - FRAC))) begin
            q = QMAG;
        end else begin
            q = (un <<< FRAC) / ud;
            if (q > QMAG) q = QMAG;
        end
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic logic [23:0] clamp24(input longint v);
        if (v > WMAX) v = WMAX;
        if (v < WMIN) v = WMIN;
        return v[23:0];
    endfunction

    function automatic t_weights barycentric(input logic [IN_DATA_W-1:0] d,
                                             input logic [15:0] tol);
        longint a[4][3];
        longint det, best_det, n0, n1, l0, l1, l2, lo, hi;
        int bi, bj, i, j;
        t_weights w;
        for (int v = 0; v < 4; v++)
            for (int c = 0; c < 3; c++)
                a[v][c] = longint'($signed(d[(v*3+c)*16 +: 16]));
        best_det = 0;
        bi = 0;
        bj = 1;
        for (int k = 0; k < 3; k++) begin
            i = pair_i(t_pair'(k));
            j = pair_j(t_pair'(k));
            det = (a[1][j] - a[2][j]) * (a[0][i] - a[2][i])
                + (a[2][i] - a[1][i]) * (a[0][j] - a[2][j]);
            if (k == 0 || mag(det) > mag(best_det)) begin
                best_det = det;
                bi = i;
                bj = j;
            end
        end
        w = '0;
        if (best_det == 0) begin
            w.degenerate = 1'b1;
            return w;
        end
        n0 = (a[1][bj] - a[2][bj]) * (a[3][bi] - a[2][bi])
           + (a[2][bi] - a[1][bi]) * (a[3][bj] - a[2][bj]);
        n1 = (a[2][bj] - a[0][bj]) * (a[3][bi] - a[2][bi])
           + (a[0][bi] - a[2][bi]) * (a[3][bj] - a[2][bj]);
        l0 = fixed_quot(n0, best_det);
        l1 = fixed_quot(n1, best_det);
        l2 = (64'sd1 <<< FRAC) - l0 - l1;
        lo = -longint'(tol);
        hi = (64'sd1 <<< FRAC) + longint'(tol);
        w.bary_0 = clamp24(l0);
        w.bary_1 = clamp24(l1);
        w.bary_2 = clamp24(l2);
        w.inside_res = (l0 >= lo && l0 <= hi && l1 >= lo && l1 <= hi
                        && l2 >= lo && l2 <= hi);
        return w;
    endfunction

    // receiver: random stall, check on each transaction
    always @(posedge i_clk) begin
        t_weights got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_weights'(m_axis_tdata[73:0]);
            if (expected_weights.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_weights.pop_front();
                if (got !== want || m_axis_tdata[79:74] !== 6'd0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch exp %h/%h/%h/%b/%b got %h/%h/%h/%b/%b",
                                 want.bary_0, want.bary_1, want.bary_2, want.inside_res,
                                 want.degenerate, got.bary_0, got.bary_1, got.bary_2,
                                 got.inside_res, got.degenerate);
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    initial begin
        wait (idle_cycles >= WATCHDOG);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_query(input logic [IN_DATA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        expected_weights.push_back(barycentric(d, tol_now));
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_weights.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic set_tolerance(input logic [15:0] t);
        drain_pipeline();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= t;
        tol_now = t;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [IN_DATA_W-1:0] pack_query(input logic [15:0] c[12]);
        logic [IN_DATA_W-1:0] d;
        for (int k = 0; k < 12; k++) d[k*16 +: 16] = c[k];
        return d;
    endfunction

    function automatic logic [15:0] rand_coord(input int span);
        if (span == 0) return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    task automatic test_directed();
        logic [15:0] c[12];
        // unit triangle in xy queried at its vertices, then a larger one at center and outside
        c = '{0,0,0, 16'd1,0,0, 0,16'd1,0, 0,0,0};
        send_query(pack_query(c));
        c[9] = 16'd1; send_query(pack_query(c));
        c[9] = 0; c[10] = 16'd1; send_query(pack_query(c));
        c = '{0,0,0, 16'd3,0,0, 0,16'd3,0, 16'd1,16'd1,0};
        send_query(pack_query(c));
        c[9] = 16'hFFFF; send_query(pack_query(c));
        // all-zero and collinear (degenerate)
        c = '{default: 16'd0};
        send_query(pack_query(c));
        c = '{16'd1,16'd1,16'd1, 16'd2,16'd2,16'd2, 16'd3,16'd3,16'd3, 16'd5,0,0};
        send_query(pack_query(c));
        // xz and yz dominant pairs, and an exact tie
        c = '{0,0,0, 16'd4,0,0, 0,0,16'd4, 16'd1,0,16'd1};
        send_query(pack_query(c));
        c = '{0,0,0, 0,16'd4,0, 0,0,16'd4, 0,16'd1,16'd1};
        send_query(pack_query(c));
        c = '{0,0,0, 16'd2,0,0, 0,16'd2,16'd2, 16'd1,0,0};
        send_query(pack_query(c));
        // coordinate extremes: huge quotients, saturation
        c = '{16'h8000,16'h8000,16'h8000, 16'h7FFF,16'h8000,16'h7FFF,
              16'h8000,16'h7FFF,16'h7FFF, 16'h7FFF,16'h7FFF,16'h8000};
        send_query(pack_query(c));
        c = '{0,0,0, 16'd1,0,0, 0,16'd1,0, 16'h7FFF,16'h7FFF,0};
        send_query(pack_query(c));
        c = '{0,0,0, 16'd1,0,0, 0,16'd1,0, 16'h8000,16'h8000,16'h7FFF};
        send_query(pack_query(c));
        c = '{16'hFFFF,16'hFFFF,16'hFFFF, 16'h7FFF,16'h7FFF,16'h7FFF,
              16'h8000,16'h8000,16'h8000, 16'hFFFF,16'hFFFF,16'hFFFF};
        send_query(pack_query(c));
        c = '{16'h7FFF,16'h7FFF,0, 16'h8000,16'h7FFF,0, 16'h7FFF,16'h8000,0,
              16'h8000,16'h8000,16'h7FFF};
        send_query(pack_query(c));
    endtask

    task automatic test_random(input int count);
        logic [15:0] c[12];
        int span;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(5))
                0: span = 0;
                1: span = 4;
                2: span = 100;
                default: span = 3000;
            endcase
            for (int k = 0; k < 9; k++) c[k] = rand_coord(span);
            if ($urandom_range(9) == 0) begin
                // coincident vertices: v2 copies v1
                c[6:8] = c[3:5];
            end
            if ($urandom_range(2) != 0) begin
                // query near the triangle: v2 + small mix of edges
                for (int k = 0; k < 3; k++)
                    c[9+k] = c[6+k] + 16'(($signed(c[k] - c[6+k]) * $urandom_range(5)) / 4)
                           + 16'(($signed(c[3+k] - c[6+k]) * $urandom_range(5)) / 4)
                           + 16'($urandom_range(4) - 2);
            end else begin
                for (int k = 9; k < 12; k++) c[k] = rand_coord(span);
            end
            send_query(pack_query(c));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        tol_now = '0;
        n_errors = 0;
        idle_cycles = 0;
        send_idle_pct = 11;
        recv_idle_pct = 59;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        set_tolerance(16'hFFFF);
        test_directed();
        test_random(450);
        set_tolerance(16'd300);
        send_idle_pct = 59;
        recv_idle_pct = 11;
        test_random(450);
        set_tolerance(16'd0);
        test_random(450);
        set_tolerance(16'd4096);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);

        drain_pipeline();
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
